### src/lpld_pkg.sv
`timescale 1ns / 1ps

package lpld_pkg;

    localparam int NUM_THRESH   = 6;
    localparam int THRESH_WIDTH = 16;
    localparam int LEVEL_WIDTH  = 4;
    localparam int COUNT_WIDTH  = 3;

    typedef logic [THRESH_WIDTH-1:0] thresh_t;
    typedef logic signed [LEVEL_WIDTH-1:0] level_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [2:0] {
        REG_ACTIVE_LEVEL = 3'd0,
        REG_LEVEL_COUNT  = 3'd1,
        REG_THRESHOLD_0  = 3'd2,
        REG_THRESHOLD_1  = 3'd3,
        REG_THRESHOLD_2  = 3'd4,
        REG_THRESHOLD_3  = 3'd5,
        REG_THRESHOLD_4  = 3'd6,
        REG_THRESHOLD_5  = 3'd7
    } cfg_index_t;

    localparam logic      ACTIVE_LEVEL_RST = 1'b0;
    localparam count_t    LEVEL_COUNT_RST  = 3'd1;
    localparam level_t    LEVEL_NONE       = -4'sd1;
    localparam thresh_t   THRESH_RST [NUM_THRESH] =
        '{16'd0, 16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd5000};

endpackage

### src/long_press_level_detector.sv
`timescale 1ns / 1ps

// The result word for an accepted input word is registered and appears on the output in the cycle after acceptance.
// Throughput: one word per cycle; the output register holds a stalled result and
// in_ready stays high whenever that register is empty or being drained.
// Reset (async, active low): previous sample 0, elapsed 0, held level -1,
// registers back to defaults (active low pin, one threshold, 0/1000/.../5000 ms).
module long_press_level_detector #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  lpld_pkg::cfg_index_t     cfg_index,
    input  lpld_pkg::thresh_t        cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     pin_sample,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     is_on,
    output logic                     changed,
    output logic                     released,
    output lpld_pkg::level_t         held_level,
    output logic                     level_up,
    output logic                     beep
);
    import lpld_pkg::*;

    localparam int CMP_WIDTH = (TIME_WIDTH > THRESH_WIDTH) ? TIME_WIDTH : THRESH_WIDTH;
    localparam int IDX_WIDTH = $clog2(NUM_THRESH);

    // configuration
    logic    active_level_reg;
    count_t  level_count_reg;
    thresh_t thresh_reg [NUM_THRESH];

    // tracking state
    logic                  prev_sample_reg;
    logic [TIME_WIDTH-1:0] elapsed_reg;
    level_t                level_reg;

    // result word
    logic   out_valid_reg;
    logic   is_on_reg, changed_reg, released_reg, level_up_reg, beep_reg;
    level_t held_level_reg;

    logic                  in_fire;
    logic                  cur_on, cur_changed, cur_released, cur_up, cur_beep;
    logic [TIME_WIDTH-1:0] elapsed_inc;
    logic [TIME_WIDTH-1:0] elapsed_next;
    level_t                level_next;
    count_t                count_eff;
    logic [NUM_THRESH-1:0] hit;
    logic [IDX_WIDTH-1:0]  cand;
    level_t                cand_lvl;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= ACTIVE_LEVEL_RST;
            level_count_reg  <= LEVEL_COUNT_RST;
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thresh_reg[i] <= THRESH_RST[i];
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                REG_LEVEL_COUNT:  level_count_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_THRESHOLD_0:  thresh_reg[0]    <= cfg_data;
                REG_THRESHOLD_1:  thresh_reg[1]    <= cfg_data;
                REG_THRESHOLD_2:  thresh_reg[2]    <= cfg_data;
                REG_THRESHOLD_3:  thresh_reg[3]    <= cfg_data;
                REG_THRESHOLD_4:  thresh_reg[4]    <= cfg_data;
                REG_THRESHOLD_5:  thresh_reg[5]    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cur_on      = (pin_sample == active_level_reg);
    assign cur_changed = (pin_sample != prev_sample_reg);
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign count_eff   = (level_count_reg > count_t'(NUM_THRESH)) ?
                         count_t'(NUM_THRESH) : level_count_reg;

    // compare against the post-increment elapsed time
    always_comb
    begin
        for (int j = 0; j < NUM_THRESH; j++)
        begin
            hit[j] = (count_t'(j) < count_eff) &&
                     (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(thresh_reg[j]));
        end
        cand = '0;
        for (int j = 0; j < NUM_THRESH; j++)
        begin
            if (hit[j])
            begin
                cand = IDX_WIDTH'(j);
            end
        end
    end

    assign cand_lvl = level_t'({1'b0, cand});

    always_comb
    begin
        elapsed_next = elapsed_inc;
        level_next   = level_reg;
        cur_released = 1'b0;
        cur_up       = 1'b0;
        cur_beep     = 1'b0;
        if (cur_changed)
        begin
            if (cur_on)
            begin
                elapsed_next = '0;
                level_next   = LEVEL_NONE;
            end
            else
            begin
                cur_released = 1'b1;
            end
        end
        else if (cur_on && (cand_lvl > level_reg))
        begin
            level_next = cand_lvl;
            cur_up     = 1'b1;
            cur_beep   = (cand != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= 1'b0;
            elapsed_reg     <= '0;
            level_reg       <= LEVEL_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                prev_sample_reg <= pin_sample;
                elapsed_reg     <= elapsed_next;
                level_reg       <= level_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            is_on_reg      <= cur_on;
            changed_reg    <= cur_changed;
            released_reg   <= cur_released;
            held_level_reg <= level_next;
            level_up_reg   <= cur_up;
            beep_reg       <= cur_beep;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_on      = is_on_reg;
    assign changed    = changed_reg;
    assign released   = released_reg;
    assign held_level = held_level_reg;
    assign level_up   = level_up_reg;
    assign beep       = beep_reg;

    a_beep_needs_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beep |-> level_up)
        else $error("beep without level_up");

    a_release_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && released |-> changed && !is_on)
        else $error("released word is not a release edge");

    a_up_only_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level_up |-> !changed && is_on && (held_level != LEVEL_NONE))
        else $error("level_up outside a steady press");

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> held_level == level_reg)
        else $error("result level differs from tracked level");

endmodule

### dv/tb_long_press_level_detector.sv
`timescale 1ns / 1ps

module tb_long_press_level_detector;

    import lpld_pkg::*;

    localparam int TIME_W = 16;

    typedef struct packed {
        logic   is_on;
        logic   changed;
        logic   released;
        level_t held_level;
        logic   level_up;
        logic   beep;
    } tick_report_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index  = REG_ACTIVE_LEVEL;
    thresh_t    cfg_data   = '0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       pin_sample = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       is_on;
    logic       changed;
    logic       released;
    level_t     held_level;
    logic       level_up;
    logic       beep;

    // detector copy: registers and tick state
    logic              act_lvl   = ACTIVE_LEVEL_RST;
    count_t            lvl_count = LEVEL_COUNT_RST;
    thresh_t           thr [NUM_THRESH] = THRESH_RST;
    logic              prev_pin  = 1'b0;
    logic [TIME_W-1:0] hold_ms   = '0;
    level_t            cur_level = LEVEL_NONE;

    tick_report_t tick_reports [$];
    int           mismatch_count = 0;
    bit           calm = 1'b0;
    int           rx_hold = 0;

    long_press_level_detector #(
        .TIME_WIDTH (TIME_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_sample (pin_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_on      (is_on),
        .changed    (changed),
        .released   (released),
        .held_level (held_level),
        .level_up   (level_up),
        .beep       (beep)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic tick_report_t step_detector(input logic s);
        tick_report_t r;
        int n;
        int cand;
        r = '0;
        r.changed = (s != prev_pin);
        r.is_on   = (s == act_lvl);
        prev_pin  = s;
        if (r.changed && r.is_on)
        begin
            hold_ms   = '0;
            cur_level = LEVEL_NONE;
        end
        else
        begin
            r.released = r.changed;
            if (hold_ms != '1)
                hold_ms = hold_ms + 1'b1;
            if (!r.changed && r.is_on)
            begin
                n = (lvl_count > NUM_THRESH) ? NUM_THRESH : int'(lvl_count);
                cand = 0;
                for (int j = 0; j < n; j++)
                    if (hold_ms >= thr[j])
                        cand = j;
                if (cand > int'(cur_level))
                begin
                    cur_level  = level_t'(cand);
                    r.level_up = 1'b1;
                    r.beep     = (cand > 0);
                end
            end
        end
        r.held_level = cur_level;
        return r;
    endfunction

    task automatic compare_field(input string fname, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, fname, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tick_report_t want;
        if (out_valid && out_ready)
        begin
            if (tick_reports.size() == 0)
            begin
                $display("%0t: result word with nothing expected, held_level %0d",
                         $time, int'(held_level));
                mismatch_count++;
            end
            else
            begin
                want = tick_reports.pop_front();
                compare_field("is_on", want.is_on, is_on);
                compare_field("changed", want.changed, changed);
                compare_field("released", want.released, released);
                compare_field("held_level", int'($signed(want.held_level)),
                              int'(held_level));
                compare_field("level_up", want.level_up, level_up);
                compare_field("beep", want.beep, beep);
            end
            rx_hold = draw_gap();
            out_ready <= (rx_hold == 0);
        end
        else if (!out_ready)
        begin
            if (rx_hold > 0)
                rx_hold--;
            out_ready <= (rx_hold == 0);
        end
    end

    task automatic send_tick(input logic s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_sample <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tick_reports.push_back(step_detector(s));
    endtask

    // drop valid and let every outstanding word come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tick_reports.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input thresh_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ACTIVE_LEVEL: act_lvl = val[0];
            REG_LEVEL_COUNT:  lvl_count = val[COUNT_WIDTH-1:0];
            default:          thr[int'(idx) - int'(REG_THRESHOLD_0)] = val;
        endcase
    endtask

    // reset registers: active low pin, one threshold at 0 ms
    task automatic test_power_on_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_level_climb();
        wait_idle();
        write_reg(REG_ACTIVE_LEVEL, 16'd1);
        write_reg(REG_LEVEL_COUNT, 16'd3);
        write_reg(REG_THRESHOLD_0, 16'd2);
        write_reg(REG_THRESHOLD_1, 16'd4);
        write_reg(REG_THRESHOLD_2, 16'd6);
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (7) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // zero thresholds in use, then a count past six
    task automatic test_level_count_limits();
        wait_idle();
        write_reg(REG_LEVEL_COUNT, 16'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
        write_reg(REG_LEVEL_COUNT, 16'd7);
        write_reg(REG_THRESHOLD_5, 16'd1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // long hold past the low thresholds; the top ones stay out of reach
    task automatic test_long_hold();
        wait_idle();
        write_reg(REG_ACTIVE_LEVEL, 16'd1);
        write_reg(REG_LEVEL_COUNT, 16'd6);
        write_reg(REG_THRESHOLD_0, 16'd0);
        write_reg(REG_THRESHOLD_1, 16'd1);
        write_reg(REG_THRESHOLD_2, 16'd100);
        write_reg(REG_THRESHOLD_3, 16'd30000);
        write_reg(REG_THRESHOLD_4, 16'hFFFE);
        write_reg(REG_THRESHOLD_5, 16'hFFFF);
        send_tick(1'b0);
        send_tick(1'b1);
        for (int i = 0; i < 120; i++)
        begin
            calm = ((i % 32) < 16);
            send_tick(1'b1);
        end
        calm = 1'b0;
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    task automatic test_random_holds();
        int sent;
        int len;
        int off;
        int base;
        thresh_t word;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            calm = 1'b0;
            // upper data bits are don't-care for the narrow registers
            word = thresh_t'($urandom_range(0, 16'hFFFF));
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_reg(REG_ACTIVE_LEVEL, word);
            word = thresh_t'($urandom_range(0, 16'hFFFF));
            case (phase)
                0:       word[COUNT_WIDTH-1:0] = 3'd0;
                1:       word[COUNT_WIDTH-1:0] = 3'd7;
                2:       word[COUNT_WIDTH-1:0] = 3'd6;
                default: ;
            endcase
            write_reg(REG_LEVEL_COUNT, word);
            base = $urandom_range(0, 10);
            for (int k = 0; k < NUM_THRESH; k++)
            begin
                base = base + $urandom_range(0, 20);
                if (phase == 2)
                    word = (k % 2) ? 16'hFFFF : 16'h0000;
                else if ($urandom_range(0, 4) == 0)
                    word = thresh_t'($urandom_range(0, 16'hFFFF));
                else
                    word = thresh_t'(base);
                if (phase < 3 || $urandom_range(0, 3) != 0)
                    write_reg(cfg_index_t'(int'(REG_THRESHOLD_0) + k), word);
            end

            sent = 0;
            while (sent < 150)
            begin
                calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 7) == 0)
                begin
                    len = $urandom_range(1, 12);
                    repeat (len) send_tick(1'($urandom_range(0, 1)));
                end
                else
                begin
                    off = $urandom_range(0, 3);
                    len = $urandom_range(0, 60);
                    repeat (off) send_tick(~act_lvl);
                    send_tick(act_lvl);
                    for (int h = 0; h < len; h++)
                        send_tick(($urandom_range(0, 39) == 0) ? ~act_lvl : act_lvl);
                    send_tick(~act_lvl);
                    len = len + off + 2;
                end
                sent += len;
                if ($urandom_range(0, 24) == 0)
                    wait_idle();
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int spins;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_level_climb();
        test_level_count_limits();
        test_long_hold();
        test_random_holds();

        in_valid <= 1'b0;
        spins = 0;
        while (tick_reports.size() != 0 && spins < 1000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (4) @(posedge clk);
        if (tick_reports.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, tick_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("long_press_level_detector verification clean");
        else
            $display("long_press_level_detector verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("long_press_level_detector verification failed");
        $finish;
    end

endmodule
